// ----- src/scl_pkg.sv -----
// Package with shared types and constants for the serial command line parser.
package scl_pkg;

  localparam int ArgSlotsDefault = 9;
  localparam int HexDigitLimitDefault = 16;

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ReadBit = 8'h40;

  typedef enum logic [4:0] {
    ACT_ECHO     = 5'd0,
    ACT_REGACC   = 5'd1,
    ACT_BAUD     = 5'd2,
    ACT_COUNTERS = 5'd3,
    ACT_CONSUMER = 5'd4,
    ACT_DISPLAY  = 5'd5,
    ACT_VERSION  = 5'd6,
    ACT_MEASOUT  = 5'd7,
    ACT_STOP     = 5'd8,
    ACT_START    = 5'd9,
    ACT_RDCAL    = 5'd10,
    ACT_WRCAL    = 5'd11,
    ACT_LOG      = 5'd12,
    ACT_RDDAC    = 5'd13,
    ACT_WRDAC    = 5'd14,
    ACT_LOOPS    = 5'd15,
    ACT_RESET    = 5'd16,
    ACT_STAIRS   = 5'd17,
    ACT_CANCEL   = 5'd18,
    ACT_SYNC     = 5'd19,
    ACT_TEXTOUT  = 5'd20,
    ACT_USAGE    = 5'd21
  } action_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
    logic signed [15:0] arg_a;
    logic signed [15:0] arg_b;
    logic signed [15:0] arg_c;
    logic signed [15:0] arg_d;
    logic signed [15:0] arg_e;
    logic signed [15:0] arg_f;
  } result_t;

endpackage

// ----- src/scl_core.sv -----
// Parser state and per-character decode, producing at most one result per character.
module scl_core import scl_pkg::*; #(
  parameter int ARG_SLOTS = ArgSlotsDefault,
  parameter int HEX_DIGIT_LIMIT = HexDigitLimitDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         kind,
  input  logic [7:0]   char_in,
  output logic         res_valid,
  output result_t      res
);

  localparam int HexBytes = HEX_DIGIT_LIMIT / 2;
  localparam int HbW = $clog2(HexBytes);
  localparam int AcW = $clog2(ARG_SLOTS + 1);
  localparam int AiW = $clog2(ARG_SLOTS);
  localparam int HdW = $clog2(HEX_DIGIT_LIMIT + 1);

  logic comment_on, escape_seen, hex_mode, negative, staircase_running;
  logic [7:0] digit_count;
  logic [31:0] number_acc;
  logic [AcW-1:0] arg_count;
  logic [15:0] arg_store [ARG_SLOTS];
  logic [HdW-1:0] hex_digits;
  logic [7:0] hex_bytes [HexBytes];

  logic comment_on_next, escape_seen_next, hex_mode_next, negative_next, stair_next;
  logic [7:0] digit_count_next;
  logic [31:0] number_acc_next;
  logic [AcW-1:0] arg_count_next;
  logic [HdW-1:0] hex_digits_next;
  logic arg_we, hex_we, hex_low;
  logic [3:0] hex_val;
  logic [HbW-1:0] hex_slot;
  logic emit;
  result_t r;

  logic signed [31:0] acc;
  logic signed [15:0] a0, a1, a2, a3, a4, a5;
  logic [31:0] acc10, dval;
  logic [HdW-2:0] nbytes;
  logic is_hex;
  logic [7:0] ch;

  assign ch = char_in;
  assign acc = number_acc;
  assign a0 = arg_store[0];
  assign a1 = arg_store[1];
  assign a2 = arg_store[2];
  assign a3 = arg_store[3];
  assign a4 = arg_store[4];
  assign a5 = arg_store[5];
  assign acc10 = (number_acc << 3) + (number_acc << 1);
  assign dval = {28'd0, ch[3:0]};
  assign nbytes = hex_digits[HdW-1:1];
  assign hex_slot = nbytes[HbW-1:0];
  assign res_valid = step && emit;
  assign res = r;

  always_comb begin
    is_hex = 1'b1;
    hex_val = ch[3:0];
    if (ch >= "a" && ch <= "f") hex_val = 4'(ch - 8'd87);
    else if (ch >= "A" && ch <= "F") hex_val = 4'(ch - 8'd55);
    else if (ch >= "0" && ch <= "9") hex_val = ch[3:0];
    else is_hex = 1'b0;
  end

  always_comb begin
    comment_on_next = comment_on;
    escape_seen_next = escape_seen;
    hex_mode_next = hex_mode;
    negative_next = negative;
    stair_next = staircase_running;
    digit_count_next = digit_count;
    number_acc_next = number_acc;
    arg_count_next = arg_count;
    hex_digits_next = hex_digits;
    arg_we = 1'b0;
    hex_we = 1'b0;
    hex_low = hex_digits[0];
    emit = 1'b0;
    r = '0;
    if (kind) begin
      stair_next = 1'b0;
    end else if (ch == ChHash) begin
      comment_on_next = 1'b1;
      emit = 1'b1;
      r.action = ACT_ECHO;
      r.value = {24'd0, ch};
    end else if (comment_on) begin
      if (ch != ChCr) begin
        emit = 1'b1;
        r.action = ACT_ECHO;
        r.value = {24'd0, ch};
      end
      if (ch == ChLf) comment_on_next = 1'b0;
    end else if (escape_seen) begin
      if (ch == "y") hex_mode_next = 1'b1;
      escape_seen_next = 1'b0;
    end else if (hex_mode) begin
      if (ch == ChSemi) begin
        hex_mode_next = 1'b0;
        if (!hex_digits[0] && hex_digits != '0) begin
          emit = 1'b1;
          r.action = ACT_REGACC;
          if (nbytes == 2) r.value = {24'd0, hex_bytes[1]};
          else if (nbytes == 3) r.value = {16'd0, hex_bytes[1], hex_bytes[2]};
          else if (nbytes == 4 && HexBytes > 3)
            r.value = {8'd0, hex_bytes[1], hex_bytes[2], hex_bytes[HexBytes > 3 ? 3 : 0]};
          r.arg_a = {8'd0, hex_bytes[0] & ~ReadBit};
          r.arg_b = 16'(nbytes);
          r.arg_c = {15'd0, |(hex_bytes[0] & ReadBit)};
        end
      end else if (hex_digits < HdW'(HEX_DIGIT_LIMIT)) begin
        if (is_hex) begin
          hex_we = 1'b1;
          hex_digits_next = hex_digits + 1'b1;
        end else begin
          hex_mode_next = 1'b0;
        end
      end else begin
        hex_mode_next = 1'b0;
      end
    end else begin
      unique case (ch) inside
        ChColon: begin
          escape_seen_next = 1'b1;
          hex_digits_next = '0;
        end
        "c": begin emit = 1'b1; r.action = ACT_COUNTERS; end
        "e": begin emit = 1'b1; r.action = ACT_VERSION; end
        "k": begin emit = 1'b1; r.action = ACT_RDCAL; end
        "y": begin emit = 1'b1; r.action = ACT_SYNC; end
        "S": begin emit = staircase_running; r.action = ACT_CANCEL; end
        "B", "C", "d", "h", "K", "l", "r", "z", "R", "j": begin
          emit = digit_count != 0;
          r.value = number_acc;
          case (ch)
            "B": begin r.action = ACT_BAUD; emit = emit && acc >= 1 && acc <= 5; end
            "C": begin r.action = ACT_CONSUMER; emit = emit && (acc == 0 || acc == 1); end
            "d": r.action = ACT_DISPLAY;
            "h": r.action = ACT_MEASOUT;
            "K": r.action = ACT_WRCAL;
            "l": r.action = ACT_LOG;
            "r": r.action = ACT_LOOPS;
            "z": r.action = ACT_TEXTOUT;
            "R": begin
              r.action = ACT_RESET;
              emit = emit && digit_count == 1 && arg_count == '0 && acc == 1 && !negative;
            end
            default: begin
              r.action = (acc == 0) ? ACT_STOP : ACT_START;
              emit = emit && (acc == 0 || acc == 1);
            end
          endcase
          if (!emit) r = '0;
          digit_count_next = '0;
          arg_count_next = '0;
          negative_next = 1'b0;
        end
        "m": begin
          emit = 1'b1;
          if (arg_count == AcW'(1) && digit_count == 1 && a0 >= 0 && a0 < 4
              && acc >= 0 && acc < 2) begin
            r.action = ACT_RDDAC;
            r.value = number_acc;
            r.arg_a = a0;
          end else begin
            r.action = ACT_USAGE;
          end
          digit_count_next = '0;
          arg_count_next = '0;
          negative_next = 1'b0;
        end
        "M": begin
          emit = 1'b1;
          if (arg_count == AcW'(6) && digit_count == 1 && a0 >= 0 && a0 < 4
              && a1 >= 0 && a1 < 2 && a2 >= 0 && a2 < 4096 && a3 >= 0 && a3 < 2
              && a4 >= 0 && a4 < 2 && a5 >= 0 && a5 < 4 && acc >= 0 && acc < 2) begin
            r.action = ACT_WRDAC;
            r.value = number_acc;
            r.arg_a = a0; r.arg_b = a1; r.arg_c = a2;
            r.arg_d = a3; r.arg_e = a4; r.arg_f = a5;
          end else begin
            r.action = ACT_USAGE;
            r.arg_a = 16'sd1;
          end
          digit_count_next = '0;
          arg_count_next = '0;
          negative_next = 1'b0;
        end
        "s": begin
          emit = 1'b1;
          if (!staircase_running && arg_count == AcW'(3) && digit_count != 0
              && a0 >= 0 && a0 < 4 && a1 >= 0 && a1 < 4096 && a2 != 0 && a2 < 256
              && acc != 0 && acc < 256) begin
            stair_next = 1'b1;
            r.action = ACT_STAIRS;
            r.value = number_acc;
            r.arg_a = a0; r.arg_b = a1; r.arg_c = a2;
          end else begin
            r.action = ACT_USAGE;
            r.arg_a = 16'sd2;
          end
          digit_count_next = '0;
          arg_count_next = '0;
          negative_next = 1'b0;
        end
        ChComma: begin
          if (digit_count != 0 && arg_count < AcW'(ARG_SLOTS)) begin
            arg_we = 1'b1;
            arg_count_next = arg_count + 1'b1;
            digit_count_next = '0;
            negative_next = 1'b0;
          end
        end
        ChMinus: begin
          if (digit_count == 0) negative_next = 1'b1;
        end
        ChLf: begin
          digit_count_next = '0;
          arg_count_next = '0;
          negative_next = 1'b0;
        end
        default: begin
          if (ch >= "0" && ch <= "9") begin
            number_acc_next = ((digit_count == 0) ? 32'd0 : acc10)
                              + (negative ? (32'd0 - dval) : dval);
            if (digit_count != 8'd255) digit_count_next = digit_count + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comment_on <= 1'b0;
      escape_seen <= 1'b0;
      hex_mode <= 1'b0;
      negative <= 1'b0;
      staircase_running <= 1'b0;
      digit_count <= '0;
      number_acc <= '0;
      arg_count <= '0;
      hex_digits <= '0;
    end else if (step) begin
      comment_on <= comment_on_next;
      escape_seen <= escape_seen_next;
      hex_mode <= hex_mode_next;
      negative <= negative_next;
      staircase_running <= stair_next;
      digit_count <= digit_count_next;
      number_acc <= number_acc_next;
      arg_count <= arg_count_next;
      hex_digits <= hex_digits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (arg_we) arg_store[arg_count[AiW-1:0]] <= number_acc[15:0];
      if (hex_we) begin
        if (hex_low) hex_bytes[hex_slot] <= hex_bytes[hex_slot] | {4'd0, hex_val};
        else hex_bytes[hex_slot] <= {hex_val, 4'd0};
      end
    end
  end

endmodule

// ----- src/scl_out.sv -----
// Output skid buffer that decouples the result stream from the parser.
module scl_out import scl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    space,
  output logic    m_axis_tvalid,
  input  logic    m_axis_tready,
  output result_t m_axis_data
);

  logic    full0, full1;
  result_t buf0, buf1;

  assign m_axis_tvalid = full0;
  assign m_axis_data = buf0;
  assign space = !full1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full0 <= 1'b0;
      full1 <= 1'b0;
    end else begin
      if (full0 && m_axis_tready) begin
        if (full1) begin
          full1 <= in_valid;
          full0 <= 1'b1;
        end else begin
          full0 <= in_valid;
        end
      end else if (in_valid) begin
        if (full0) full1 <= 1'b1;
        else full0 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (full0 && m_axis_tready) begin
      if (full1) begin
        buf0 <= buf1;
        buf1 <= in_data;
      end else begin
        buf0 <= in_data;
      end
    end else if (in_valid) begin
      if (full0) buf1 <= in_data;
      else buf0 <= in_data;
    end
  end

endmodule

// ----- src/serial_command_line_parser_unit.sv -----
// Top level of the serial command line parser with stream input and output.
// One character or staircase-finished transaction is taken per clock cycle while the
// output buffer has space; its result, if any, is registered into a two-entry output
// buffer. Input is stalled only while that buffer is full, since the parser updates all of
// its state for each character as it is taken.
module serial_command_line_parser_unit import scl_pkg::*; #(
  parameter int ARG_SLOTS = ArgSlotsDefault,
  parameter int HEX_DIGIT_LIMIT = HexDigitLimitDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // char_in[7:0]
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // action[4:0], value[36:5], arg_a..arg_f, zero pad
);

  logic    step, res_valid, space;
  result_t res, outd;

  assign s_axis_tready = space;
  assign step = s_axis_tvalid && space;

  scl_core #(.ARG_SLOTS(ARG_SLOTS), .HEX_DIGIT_LIMIT(HEX_DIGIT_LIMIT)) u_core (
    .clk(clk), .rst(rst), .step(step), .kind(s_axis_tuser), .char_in(s_axis_tdata),
    .res_valid(res_valid), .res(res)
  );

  scl_out u_out (
    .clk(clk), .rst(rst), .in_valid(res_valid), .in_data(res), .space(space),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_data(outd)
  );

  assign m_axis_tdata = {3'd0, outd.arg_f, outd.arg_e, outd.arg_d, outd.arg_c,
                         outd.arg_b, outd.arg_a, outd.value, outd.action};

endmodule

// ----- sim/serial_command_line_parser_unit_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts the parser's actions and compares them with its output stream.
module serial_command_line_parser_unit_checker import scl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  output int           fail_count,
  output int           pending
);

  localparam int ArgSlots = ArgSlotsDefault;
  localparam int HexLimit = HexDigitLimitDefault;

  bit          comment_on, escape_seen, hex_mode, negative, stairs_busy;
  logic [7:0]  digit_count;
  logic [31:0] number_acc;
  logic [3:0]  arg_count;
  logic [15:0] arg_store [ArgSlots];
  logic [4:0]  hex_digits;
  logic [7:0]  hex_bytes [HexLimit / 2];

  result_t expected_actions [$];

  initial fail_count = 0;
  assign pending = expected_actions.size();

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic logic signed [15:0] arg_at(input int i);
    return $signed(arg_store[i]);
  endfunction

  function automatic result_t make_action(input action_t a, input logic [31:0] v);
    result_t r;
    r = '0;
    r.action = a;
    r.value = v;
    return r;
  endfunction

  function automatic void clear_line();
    digit_count = 0;
    arg_count = 0;
    negative = 0;
  endfunction

  function automatic bit value_command(input action_t a, input bit ok, output result_t r);
    bit has;
    has = (digit_count != 0) && ok;
    r = make_action(a, number_acc);
    clear_line();
    return has;
  endfunction

  function automatic bit parse_hex(input logic [7:0] ch, output result_t r);
    int nbytes, slot;
    logic [3:0] v;
    logic [31:0] data;
    r = '0;
    if (ch == ChSemi) begin
      hex_mode = 0;
      if (hex_digits[0] || hex_digits == 0) return 0;
      nbytes = hex_digits >> 1;
      data = 0;
      if (nbytes == 2) data = hex_bytes[1];
      else if (nbytes == 3) data = {hex_bytes[1], hex_bytes[2]};
      else if (nbytes == 4) data = {hex_bytes[1], hex_bytes[2], hex_bytes[3]};
      r = make_action(ACT_REGACC, data);
      r.arg_a = {8'h00, hex_bytes[0] & ~ReadBit};
      r.arg_b = 16'(nbytes);
      r.arg_c = (hex_bytes[0] & ReadBit) != 0 ? 16'sd1 : 16'sd0;
      return 1;
    end
    if (hex_digits < HexLimit) begin
      slot = (hex_digits >> 1) % (HexLimit / 2);
      if (ch >= "a" && ch <= "f") v = 4'(ch - "a" + 10);
      else if (ch >= "A" && ch <= "F") v = 4'(ch - "A" + 10);
      else if (ch >= "0" && ch <= "9") v = 4'(ch - "0");
      else begin
        hex_mode = 0;
        return 0;
      end
      if (hex_digits[0]) hex_bytes[slot] = hex_bytes[slot] | {4'h0, v};
      else hex_bytes[slot] = {v, 4'h0};
      hex_digits++;
    end else begin
      hex_mode = 0;
    end
    return 0;
  endfunction

  function automatic bit parse_plain(input logic [7:0] ch, output result_t r);
    logic signed [31:0] acc;
    bit has;
    logic [31:0] d;
    acc = $signed(number_acc);
    r = '0;
    has = 0;
    case (ch)
      ChColon: begin
        escape_seen = 1;
        hex_digits = 0;
      end
      "B": has = value_command(ACT_BAUD, acc >= 1 && acc <= 5, r);
      "c": begin r = make_action(ACT_COUNTERS, 0); has = 1; end
      "C": has = value_command(ACT_CONSUMER, acc == 0 || acc == 1, r);
      "d": has = value_command(ACT_DISPLAY, 1, r);
      "e": begin r = make_action(ACT_VERSION, 0); has = 1; end
      "h": has = value_command(ACT_MEASOUT, 1, r);
      "j": begin
        if (digit_count != 0 && (acc == 0 || acc == 1)) begin
          r = make_action(acc == 0 ? ACT_STOP : ACT_START, number_acc);
          has = 1;
        end
        clear_line();
      end
      "k": begin r = make_action(ACT_RDCAL, 0); has = 1; end
      "K": has = value_command(ACT_WRCAL, 1, r);
      "l": has = value_command(ACT_LOG, 1, r);
      "m": begin
        if (arg_count == 1 && digit_count == 1 && arg_at(0) >= 0 && arg_at(0) < 4 &&
            acc >= 0 && acc < 2) begin
          r = make_action(ACT_RDDAC, number_acc);
          r.arg_a = arg_store[0];
        end else begin
          r = make_action(ACT_USAGE, 0);
        end
        has = 1;
        clear_line();
      end
      "M": begin
        if (arg_count == 6 && digit_count == 1 &&
            arg_at(0) >= 0 && arg_at(0) < 4 && arg_at(1) >= 0 && arg_at(1) < 2 &&
            arg_at(2) >= 0 && arg_at(2) < 4096 && arg_at(3) >= 0 && arg_at(3) < 2 &&
            arg_at(4) >= 0 && arg_at(4) < 2 && arg_at(5) >= 0 && arg_at(5) < 4 &&
            acc >= 0 && acc < 2) begin
          r = make_action(ACT_WRDAC, number_acc);
          r.arg_a = arg_store[0];
          r.arg_b = arg_store[1];
          r.arg_c = arg_store[2];
          r.arg_d = arg_store[3];
          r.arg_e = arg_store[4];
          r.arg_f = arg_store[5];
        end else begin
          r = make_action(ACT_USAGE, 0);
          r.arg_a = 1;
        end
        has = 1;
        clear_line();
      end
      "r": has = value_command(ACT_LOOPS, 1, r);
      "R": has = value_command(ACT_RESET,
                               digit_count == 1 && arg_count == 0 && acc == 1 && !negative, r);
      "s": begin
        if (!stairs_busy && arg_count == 3 && digit_count > 0 &&
            arg_at(0) >= 0 && arg_at(0) < 4 && arg_at(1) >= 0 && arg_at(1) < 4096 &&
            arg_at(2) != 0 && arg_at(2) < 256 && acc != 0 && acc < 256) begin
          stairs_busy = 1;
          r = make_action(ACT_STAIRS, number_acc);
          r.arg_a = arg_store[0];
          r.arg_b = arg_store[1];
          r.arg_c = arg_store[2];
        end else begin
          r = make_action(ACT_USAGE, 0);
          r.arg_a = 2;
        end
        has = 1;
        clear_line();
      end
      "S": if (stairs_busy) begin r = make_action(ACT_CANCEL, 0); has = 1; end
      "y": begin r = make_action(ACT_SYNC, 0); has = 1; end
      "z": has = value_command(ACT_TEXTOUT, 1, r);
      ChComma: if (digit_count != 0 && arg_count < ArgSlots) begin
        arg_store[arg_count] = number_acc[15:0];
        arg_count++;
        digit_count = 0;
        negative = 0;
      end
      ChMinus: if (digit_count == 0) negative = 1;
      ChLf: clear_line();
      default: if (ch >= "0" && ch <= "9") begin
        d = 32'(ch - "0");
        number_acc = (digit_count == 0) ? 32'd0 : number_acc * 10;
        number_acc = number_acc + (negative ? -d : d);
        if (digit_count < 255) digit_count++;
      end
    endcase
    return has;
  endfunction

  function automatic bit parse_char(input bit kind, input logic [7:0] ch, output result_t r);
    r = '0;
    if (kind) begin
      stairs_busy = 0;
      return 0;
    end
    if (ch == ChHash) begin
      comment_on = 1;
      r = make_action(ACT_ECHO, {24'h0, ch});
      return 1;
    end
    if (comment_on) begin
      if (ch == ChCr) return 0;
      if (ch == ChLf) comment_on = 0;
      r = make_action(ACT_ECHO, {24'h0, ch});
      return 1;
    end
    if (escape_seen) begin
      if (ch == "y") hex_mode = 1;
      escape_seen = 0;
      return 0;
    end
    if (hex_mode) return parse_hex(ch, r);
    return parse_plain(ch, r);
  endfunction

  always @(posedge clk) begin
    result_t r, want;
    if (rst) begin
      comment_on = 0;
      escape_seen = 0;
      hex_mode = 0;
      negative = 0;
      stairs_busy = 0;
      digit_count = 0;
      number_acc = 0;
      arg_count = 0;
      hex_digits = 0;
      expected_actions.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_actions.size() == 0) begin
          report_mismatch("action with none pending", m_axis_tdata[4:0], -1);
        end else begin
          want = expected_actions.pop_front();
          if (m_axis_tdata[4:0] != want.action)
            report_mismatch("action", m_axis_tdata[4:0], want.action);
          if ($signed(m_axis_tdata[36:5]) != want.value)
            report_mismatch("value", $signed(m_axis_tdata[36:5]), want.value);
          if ($signed(m_axis_tdata[52:37]) != want.arg_a)
            report_mismatch("arg_a", $signed(m_axis_tdata[52:37]), want.arg_a);
          if ($signed(m_axis_tdata[68:53]) != want.arg_b)
            report_mismatch("arg_b", $signed(m_axis_tdata[68:53]), want.arg_b);
          if ($signed(m_axis_tdata[84:69]) != want.arg_c)
            report_mismatch("arg_c", $signed(m_axis_tdata[84:69]), want.arg_c);
          if ($signed(m_axis_tdata[100:85]) != want.arg_d)
            report_mismatch("arg_d", $signed(m_axis_tdata[100:85]), want.arg_d);
          if ($signed(m_axis_tdata[116:101]) != want.arg_e)
            report_mismatch("arg_e", $signed(m_axis_tdata[116:101]), want.arg_e);
          if ($signed(m_axis_tdata[132:117]) != want.arg_f)
            report_mismatch("arg_f", $signed(m_axis_tdata[132:117]), want.arg_f);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        if (parse_char(s_axis_tuser, s_axis_tdata, r)) expected_actions.push_back(r);
    end
  end

endmodule

// ----- sim/serial_command_line_parser_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top that drives command text into the parser and reports the verdict.
module serial_command_line_parser_unit_tb import scl_pkg::*; ();

  localparam int ItemTarget = 1850;
  localparam int StallLimit = 3000;

  logic         clk = 0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;
  int           fail_count;
  int           pending;
  int           items_sent = 0;
  bit           idle_on = 1;
  int           hold_cycles = 0;
  bit           hold_done = 0;
  int           quiet_cycles = 0;

  always #5 clk = ~clk;

  serial_command_line_parser_unit dut (.*);

  serial_command_line_parser_unit_checker checker_i (.*);

  always @(posedge clk) begin
    if (!hold_done && items_sent >= 600) begin
      hold_done <= 1;
      hold_cycles <= 250;
      m_axis_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= !(idle_on && $urandom_range(99) < 31);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("serial_command_line_parser_unit verification failed");
      $finish;
    end
  end

  task automatic send_item(input bit kind, input logic [7:0] ch);
    while (idle_on && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= ch;
    s_axis_tuser <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(0, s[i]);
  endtask

  function automatic string number_text();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return $sformatf("%0d", $urandom_range(4));
    if (pick < 7) return $sformatf("%0d", $urandom_range(4100));
    if (pick < 8) return $sformatf("-%0d", $urandom_range(300));
    if (pick < 9) return $sformatf("%0d", $urandom_range(300));
    return $sformatf("%0d", $urandom());
  endfunction

  function automatic string hex_text();
    string s, digits;
    int n;
    digits = "0123456789abcdefABCDEF";
    s = ":y";
    n = $urandom_range(18);
    for (int i = 0; i < n; i++) s = {s, string'(digits[$urandom_range(21)])};
    if ($urandom_range(9) == 0) s = {s, string'(8'($urandom_range(255)))};
    return {s, ";"};
  endfunction

  task automatic send_random_line();
    string letters, s;
    int pick, nargs;
    letters = "BcCdehjkKlmMrRsSyz";
    pick = $urandom_range(99);
    if (pick < 50) begin
      s = "";
      nargs = $urandom_range(10);
      if ($urandom_range(2) == 0) nargs = 3 + 3 * $urandom_range(1);
      for (int i = 0; i < nargs; i++) s = {s, number_text(), ","};
      if ($urandom_range(5) != 0) s = {s, number_text()};
      s = {s, string'(letters[$urandom_range(17)])};
      if ($urandom_range(3) == 0) s = {s, "\n"};
      send_text(s);
    end else if (pick < 65) begin
      send_text(hex_text());
    end else if (pick < 73) begin
      s = "#";
      for (int i = $urandom_range(6); i > 0; i--) s = {s, string'(8'($urandom_range(255)))};
      if ($urandom_range(1)) s = {s, "\r"};
      send_text({s, "\n"});
    end else if (pick < 78) begin
      send_item(1, 8'($urandom_range(255)));
    end else if (pick < 83) begin
      send_item(0, ChColon);
      send_item(0, 8'($urandom_range(255)));
    end else begin
      send_item(0, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    string digits300;
    rst <= 1;
    s_axis_tvalid <= 0;
    s_axis_tdata <= 0;
    s_axis_tuser <= 0;
    m_axis_tready <= 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    send_text("#a\r\n");
    send_text(":y;:y4012;:y41ab12;:yC1020304;:y0102030405;:y123;:yzz");
    send_text("1B6B0C-5d3e7h0j1j2k9K4l5r1R-1R2R0z:x");
    send_text("1,1m0,1,4095,1,1,3,1M1,100,5,7sS");
    send_item(1, 8'hff);
    send_text("S2147483648d1,2,3,4,5,6,7,8,9,10,11d-,c\ny");
    send_item(0, 8'h00);
    send_item(0, 8'hff);
    digits300 = "";
    for (int i = 0; i < 300; i++) digits300 = {digits300, "9"};
    send_text({digits300, "h"});
    while (items_sent < ItemTarget) begin
      idle_on = !(items_sent >= 900 && items_sent < 1200);
      if (items_sent >= 1400 && items_sent < 1420) begin
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_random_line();
    end
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("serial_command_line_parser_unit verification clean");
    else $display("serial_command_line_parser_unit verification failed");
    $finish;
  end

endmodule
